### rtl/core/neighbour_mean_filter_3x3_defines.svh
// Assertion macros for the 3x3 neighbour-mean filter.
// Included by the top level; no other dependencies.
`ifndef NEIGHBOUR_MEAN_FILTER_3X3_DEFINES_SVH
`define NEIGHBOUR_MEAN_FILTER_3X3_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset
`define NMF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("nmf assertion failed");
// Check that a condition in one cycle leads to a consequence in the next
`define NMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nmf assertion failed");
`else
`define NMF_ASSERT(label, clk, rst, prop)
`define NMF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/core/nmf_pkg.sv
// Shared constants and types of the 3x3 neighbour-mean filter.
// No dependencies; imported by every other file of the block but the assertion macro header.
package nmf_pkg;

   // Defaults for the top-level parameters
   localparam int unsigned MAX_WIDTH_DEF   = 4096;
   localparam int unsigned PIXEL_BITS_DEF  = 16;

   // Frame height limit and row counter sizes
   localparam int unsigned MAX_HEIGHT      = 4096;
   localparam int unsigned HROW_BITS       = $clog2(MAX_HEIGHT);
   localparam int unsigned ROW_BITS        = HROW_BITS + 1;

   // Port field widths
   localparam int unsigned PORT_PIXEL_BITS = 16;
   localparam int unsigned CFG_BITS        = 13;
   localparam int unsigned CSR_INDEX_BITS  = 4;

   // Register reset values
   localparam int unsigned WIDTH_RESET     = 640;
   localparam int unsigned HEIGHT_RESET    = 480;

   // Mean of eight neighbours: divide by 2**MEAN_SHIFT
   localparam int unsigned NEIGHBOURS      = 8;
   localparam int unsigned MEAN_SHIFT      = $clog2(NEIGHBOURS);

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH     = 2;
   localparam int unsigned QPTR_BITS       = $clog2(QUEUE_DEPTH);
   localparam int unsigned QLEVEL_BITS     = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IMAGE_WIDTH  = 4'd0,
      REG_IMAGE_HEIGHT = 4'd1
   } csr_reg_type;

   // Per-item decisions made by the front
   typedef struct packed {
      logic emit;
      logic border;
      logic row_end;
      logic frame_end;
   } op_flags_type;

   typedef struct packed {
      logic                   full;
      logic                   empty;
      logic [QLEVEL_BITS-1:0] level;
   } q_stat_type;

endpackage

### rtl/core/nmf_if.sv
// Handshake channels of the 3x3 neighbour-mean filter: input, result, register write.
// Depends on nmf_pkg for field widths.
interface nmf_req_if import nmf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [PORT_PIXEL_BITS-1:0] pixel_value;
   modport source (output valid, kind, pixel_value, input ready);
   modport sink   (input valid, kind, pixel_value, output ready);
endinterface

interface nmf_rsp_if import nmf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [PORT_PIXEL_BITS-1:0] pixel_out;
   logic                       row_end;
   logic                       frame_end;
   modport source (output valid, pixel_out, row_end, frame_end, input ready);
   modport sink   (input valid, pixel_out, row_end, frame_end, output ready);
endinterface

interface nmf_csr_if import nmf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CFG_BITS-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/neighbour_mean_filter_3x3.sv
// Channel   Dir  Payload                         Accepted when
// req_ch    in   kind, pixel_value               valid && ready
// rsp_ch    out  pixel_out, row_end, frame_end   valid && ready
// csr_ch    in   index, data                     valid && ready (ready always high)
//
// One item per clock while rsp_ch is not stalled; a result is valid on rsp_ch once the item
// that completes its window has passed the queue and the line-store read stage, which
// then shifts the window and loads the result register.
// Synchronous active-high reset clears control only; line stores need no clearing pass.
// A stalled rsp_ch holds the back; req_ch stays open until both queue entries fill.
// Top level of the 3x3 neighbour-mean filter; depends on nmf_pkg, nmf_if,
// nmf_front, nmf_queue, nmf_back and the assertion macro header.
`include "neighbour_mean_filter_3x3_defines.svh"

module neighbour_mean_filter_3x3 import nmf_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   nmf_req_if.sink   req_ch,
   nmf_csr_if.sink   csr_ch,
   nmf_rsp_if.source rsp_ch
);

   localparam int unsigned COL_BITS   = $clog2(MAX_WIDTH);
   localparam int unsigned ENTRY_BITS = $bits(op_flags_type) + COL_BITS + PIXEL_BITS;

   logic                  q_push, q_pop;
   logic [ENTRY_BITS-1:0] q_data, q_head;
   q_stat_type            q_stat;

   // Classify items and track frame position
   nmf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .csr    (csr_ch),
      .q_stat (q_stat),
      .q_push (q_push),
      .q_data (q_data)
   );

   // Decouple front and back
   nmf_queue #(
      .DATA_BITS (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head_data (q_head),
      .stat      (q_stat)
   );

   // Window, line stores and result
   nmf_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_head (q_head),
      .q_stat (q_stat),
      .q_pop  (q_pop),
      .rsp    (rsp_ch)
   );

   // Front never pushes into a full queue, back never pops an empty one
   `NMF_ASSERT(a_push_room, clock, reset, q_push |-> !q_stat.full)
   `NMF_ASSERT(a_pop_data, clock, reset, q_pop |-> !q_stat.empty)
   // Push without pop raises the fill level by one
   `NMF_ASSERT_NEXT(a_level_up, clock, reset, q_push && !q_pop, q_stat.level == $past(q_stat.level) + 1'b1)
   // Last pixel of a frame is also last of its row
   `NMF_ASSERT(a_frame_row, clock, reset, rsp_ch.valid && rsp_ch.frame_end |-> rsp_ch.row_end)

endmodule

### rtl/core/nmf_front.sv
// Front of the filter: accepts items, keeps frame position counters and size
// registers, and classifies each item into a queue entry. Depends on nmf_pkg, nmf_if.
module nmf_front import nmf_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF,
   localparam int unsigned COL_BITS   = $clog2(MAX_WIDTH),
   localparam int unsigned ENTRY_BITS = $bits(op_flags_type) + COL_BITS + PIXEL_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   nmf_req_if.sink               req,
   nmf_csr_if.sink               csr,
   input  q_stat_type            q_stat,
   output logic                  q_push,
   output logic [ENTRY_BITS-1:0] q_data
);

   // Last valid index of a clamped size register value
   function automatic logic [31:0] last_index(input logic [CFG_BITS-1:0] v,
                                              input int unsigned limit);
      logic [31:0] wide;
      wide = 32'(v);
      if (wide == 32'd0) begin
         return 32'd0;
      end else if (wide > limit) begin
         return limit - 32'd1;
      end else begin
         return wide - 32'd1;
      end
   endfunction

   logic [COL_BITS-1:0]  col_last_ff, col_last_in;
   logic [HROW_BITS-1:0] row_last_ff, row_last_in;
   logic [COL_BITS-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_BITS-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;

   logic [ROW_BITS-1:0]   row_last_ext;
   logic                  in_done, out_live, restart, drain_live, do_push;
   logic [COL_BITS-1:0]   cur_in_col, cur_out_col;
   logic [ROW_BITS-1:0]   cur_in_row, cur_out_row;
   logic                  early, col_end, in_wrap, out_wrap, req_fire, csr_fire;
   op_flags_type          flags;
   logic [PIXEL_BITS-1:0] pixel;

   // Classify the offered item
   always_comb begin
      row_last_ext = ROW_BITS'(row_last_ff);
      in_done      = in_row_ff > row_last_ext;
      out_live     = out_row_ff <= row_last_ext;
      restart      = !req.kind && in_done;
      drain_live   = req.kind && in_done && out_live;
      do_push      = !req.kind || drain_live;

      // a pixel after the frame end starts a new frame
      cur_in_col  = restart ? '0 : in_col_ff;
      cur_in_row  = restart ? '0 : in_row_ff;
      cur_out_col = restart ? '0 : out_col_ff;
      cur_out_row = restart ? '0 : out_row_ff;

      // no result until one row and one column have come in
      early = (cur_in_row == '0) || ((cur_in_row == ROW_BITS'(1)) && (cur_in_col == '0));
      col_end = cur_out_col == col_last_ff;

      flags.emit      = !early && (cur_out_row <= row_last_ext);
      flags.border    = (cur_out_row == '0) || (cur_out_row == row_last_ext)
                        || (cur_out_col == '0) || col_end;
      flags.row_end   = col_end;
      flags.frame_end = col_end && (cur_out_row == row_last_ext);

      pixel  = req.kind ? '0 : req.pixel_value[PIXEL_BITS-1:0];
      q_data = {flags, cur_in_col, pixel};
   end

   // Handshakes
   assign req.ready = !q_stat.full;
   assign csr.ready = 1'b1;
   assign req_fire  = req.valid && req.ready;
   assign csr_fire  = csr.valid && csr.ready;
   assign q_push    = req_fire && do_push;

   // Advance counters, take register writes
   always_comb begin
      in_wrap     = cur_in_col == col_last_ff;
      out_wrap    = col_end;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      col_last_in = col_last_ff;
      row_last_in = row_last_ff;

      if (q_push) begin
         in_col_in  = in_wrap ? '0 : cur_in_col + 1'b1;
         in_row_in  = in_wrap ? cur_in_row + 1'b1 : cur_in_row;
         out_col_in = cur_out_col;
         out_row_in = cur_out_row;
         if (flags.emit) begin
            out_col_in = out_wrap ? '0 : cur_out_col + 1'b1;
            out_row_in = out_wrap ? cur_out_row + 1'b1 : cur_out_row;
         end
      end

      if (csr_fire) begin
         case (csr_reg_type'(csr.index))
            REG_IMAGE_WIDTH: begin
               col_last_in = COL_BITS'(last_index(csr.data, MAX_WIDTH));
               in_col_in   = '0;
               in_row_in   = '0;
               out_col_in  = '0;
               out_row_in  = '0;
            end
            REG_IMAGE_HEIGHT: begin
               row_last_in = HROW_BITS'(last_index(csr.data, MAX_HEIGHT));
               in_col_in   = '0;
               in_row_in   = '0;
               out_col_in  = '0;
               out_row_in  = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff <= COL_BITS'(last_index(CFG_BITS'(WIDTH_RESET), MAX_WIDTH));
         row_last_ff <= HROW_BITS'(last_index(CFG_BITS'(HEIGHT_RESET), MAX_HEIGHT));
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
      end else begin
         col_last_ff <= col_last_in;
         row_last_ff <= row_last_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
      end
   end

endmodule

### rtl/core/nmf_queue.sv
// Short queue between the filter front and back.
// Depends on nmf_pkg for its depth and status type.
module nmf_queue import nmf_pkg::*; #(
   parameter int unsigned DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] head_data,
   output q_stat_type           stat
);

   logic [DATA_BITS-1:0]   entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QLEVEL_BITS-1:0] level_ff, level_in;

   // Pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Store pushed entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data  = entry_ff[rd_ptr_ff];
   assign stat.full  = level_ff == QLEVEL_BITS'(QUEUE_DEPTH);
   assign stat.empty = level_ff == '0;
   assign stat.level = level_ff;

endmodule

### rtl/core/nmf_back.sv
// Back of the filter: line stores, 3x3 window, neighbour mean and result register.
// Depends on nmf_pkg and nmf_if; fed from nmf_queue.
module nmf_back import nmf_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF,
   localparam int unsigned COL_BITS   = $clog2(MAX_WIDTH),
   localparam int unsigned ENTRY_BITS = $bits(op_flags_type) + COL_BITS + PIXEL_BITS,
   localparam int unsigned SUM_BITS   = PIXEL_BITS + MEAN_SHIFT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [ENTRY_BITS-1:0] q_head,
   input  q_stat_type            q_stat,
   output logic                  q_pop,
   nmf_rsp_if.source             rsp
);

   localparam int unsigned FLAG_BITS = $bits(op_flags_type);

   // Line stores, written and read only by column
   logic [PIXEL_BITS-1:0] upper_mem  [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] middle_mem [MAX_WIDTH];

   // Window columns one and two; column zero is never read again
   logic [PIXEL_BITS-1:0] win_c1_ff [3];
   logic [PIXEL_BITS-1:0] win_c2_ff [3];

   op_flags_type          head_flags, s1_flags_ff;
   logic [COL_BITS-1:0]   head_col, s1_col_ff;
   logic [PIXEL_BITS-1:0] head_pix, s1_pix_ff;
   logic [PIXEL_BITS-1:0] rd_upper_ff, rd_mid_ff;
   logic                  s1_valid_ff, s1_valid_in;
   logic                  out_valid_ff, out_valid_in;
   logic [PORT_PIXEL_BITS-1:0] pixel_out_ff;
   logic                  row_end_ff, frame_end_ff;

   logic                  out_free, s1_adv, fwd;
   logic [SUM_BITS-1:0]   sum;
   logic [PIXEL_BITS-1:0] mean, center;

   assign head_flags = op_flags_type'(q_head[ENTRY_BITS-1 -: FLAG_BITS]);
   assign head_col   = q_head[PIXEL_BITS +: COL_BITS];
   assign head_pix   = q_head[PIXEL_BITS-1:0];

   // Stage control: advance when the item emits no result or the result register can take it
   assign out_free = !out_valid_ff || rsp.ready;
   assign s1_adv   = s1_valid_ff && (!s1_flags_ff.emit || out_free);
   assign q_pop    = !q_stat.empty && (!s1_valid_ff || s1_adv);
   // same column written this cycle: take the data being written
   assign fwd      = s1_adv && (head_col == s1_col_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (q_pop) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   // Read the line stores for the popped item, write back on advance
   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_flags_ff <= head_flags;
         s1_col_ff   <= head_col;
         s1_pix_ff   <= head_pix;
         rd_upper_ff <= fwd ? rd_mid_ff : upper_mem[head_col];
         rd_mid_ff   <= fwd ? s1_pix_ff : middle_mem[head_col];
      end
      if (s1_adv) begin
         upper_mem[s1_col_ff]  <= rd_mid_ff;
         middle_mem[s1_col_ff] <= s1_pix_ff;
      end
   end

   // Shift the window
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_c1_ff[0] <= win_c2_ff[0];
         win_c1_ff[1] <= win_c2_ff[1];
         win_c1_ff[2] <= win_c2_ff[2];
         win_c2_ff[0] <= rd_upper_ff;
         win_c2_ff[1] <= rd_mid_ff;
         win_c2_ff[2] <= s1_pix_ff;
      end
   end

   // Sum the eight neighbours of the shifted window
   always_comb begin
      sum = SUM_BITS'(win_c1_ff[0]) + SUM_BITS'(win_c2_ff[0]) + SUM_BITS'(rd_upper_ff)
          + SUM_BITS'(win_c1_ff[1]) + SUM_BITS'(rd_mid_ff)
          + SUM_BITS'(win_c1_ff[2]) + SUM_BITS'(win_c2_ff[2]) + SUM_BITS'(s1_pix_ff);
      mean   = sum[SUM_BITS-1:MEAN_SHIFT];
      center = win_c2_ff[1];
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv && s1_flags_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_flags_ff.emit) begin
         pixel_out_ff <= PORT_PIXEL_BITS'(s1_flags_ff.border ? center : mean);
         row_end_ff   <= s1_flags_ff.row_end;
         frame_end_ff <= s1_flags_ff.frame_end;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.pixel_out = pixel_out_ff;
   assign rsp.row_end   = row_end_ff;
   assign rsp.frame_end = frame_end_ff;

endmodule
